// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gpc_pkg.sv =====
package gpc_pkg;

    localparam int MAX_N     = 65536;
    localparam int MIN_N     = 4;
    localparam int ADDR_W    = $clog2(MAX_N + 1);
    localparam int J_W       = ADDR_W + 1;
    localparam int QRY_W     = 17;
    localparam int CNT_W     = 15;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_data;
        logic [ADDR_W-1:0] rd_a_addr;
        logic [ADDR_W-1:0] rd_b_addr;
    } mem_req_t;

    typedef struct packed {
        logic rd_a_data;
        logic rd_b_data;
    } mem_rsp_t;

    typedef struct packed {
        logic             start;
        logic             take;
        logic [QRY_W-1:0] query;
    } seq_ctrl_t;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic [CNT_W-1:0] count;
    } seq_stat_t;

endpackage

// ===== sv/gpc_bitmap.sv =====
module gpc_bitmap (
    input  logic              aclk,
    input  gpc_pkg::mem_req_t req,
    output gpc_pkg::mem_rsp_t rsp
);

    logic     mem_q [0:gpc_pkg::MAX_N];
    logic     rd_a_reg;
    logic     rd_b_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_q[req.wr_addr] <= req.wr_data;
        end
        rd_a_reg <= mem_q[req.rd_a_addr];
        rd_b_reg <= mem_q[req.rd_b_addr];
    end

    assign rsp.rd_a_data = rd_a_reg;
    assign rsp.rd_b_data = rd_b_reg;

endmodule

// ===== sv/gpc_seq.sv =====
module gpc_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  gpc_pkg::seq_ctrl_t ctrl,
    output gpc_pkg::seq_stat_t stat,
    output gpc_pkg::mem_req_t  req,
    input  gpc_pkg::mem_rsp_t  rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_MARK  = 4'd4;
    localparam logic [3:0] S_ADV   = 4'd5;
    localparam logic [3:0] S_QSET  = 4'd6;
    localparam logic [3:0] S_QRY   = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [gpc_pkg::ADDR_W-1:0] LAST_ADDR = gpc_pkg::ADDR_W'(gpc_pkg::MAX_N);
    localparam logic [gpc_pkg::ADDR_W-1:0] HALF_ADDR = gpc_pkg::ADDR_W'(gpc_pkg::MAX_N / 2);
    localparam logic [gpc_pkg::ADDR_W-1:0] FIRST_P   = gpc_pkg::ADDR_W'(2);

    logic [3:0]                   state_reg, state_next;
    logic                         ready_reg, ready_next;
    logic                         pend_reg;
    logic                         n_ok_reg, n_ok_next;
    logic [gpc_pkg::ADDR_W-1:0]   n_reg, n_next;
    logic [gpc_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic [gpc_pkg::ADDR_W-1:0]   q_reg, q_next;
    logic [gpc_pkg::J_W-1:0]      j_reg, j_next;
    logic [gpc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    // shared index adder
    logic [gpc_pkg::J_W-1:0]      add_a, add_b, add_s;
    logic [gpc_pkg::ADDR_W-1:0]   dec_a, dec_b, dec_s;

    always_comb begin
        if (state_reg == S_MARK) begin
            add_a = j_reg;
            add_b = gpc_pkg::J_W'(idx_reg);
        end else begin
            add_a = gpc_pkg::J_W'(idx_reg);
            add_b = gpc_pkg::J_W'(1);
        end
        add_s = add_a + add_b;
        if (state_reg == S_QSET) begin
            dec_a = n_reg;
            dec_b = FIRST_P;
        end else begin
            dec_a = q_reg;
            dec_b = gpc_pkg::ADDR_W'(1);
        end
        dec_s = dec_a - dec_b;
    end

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        n_ok_next  = n_ok_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        q_next     = q_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;

        req.wr_en     = 1'b0;
        req.wr_addr   = idx_reg;
        req.wr_data   = 1'b0;
        req.rd_a_addr = idx_reg;
        req.rd_b_addr = q_reg;

        if (pend_reg && !rsp.rd_a_data && !rsp.rd_b_data && cnt_reg != gpc_pkg::COUNT_MAX) begin
            cnt_next = cnt_reg + gpc_pkg::CNT_W'(1);
        end

        case (state_reg)
            S_IDLE: begin
                if (ctrl.start) begin
                    n_next    = gpc_pkg::ADDR_W'(ctrl.query);
                    n_ok_next = (32'(ctrl.query) >= gpc_pkg::MIN_N) &&
                                (32'(ctrl.query) <= gpc_pkg::MAX_N);
                    cnt_next  = '0;
                    if (ready_reg) begin
                        state_next = S_QSET;
                    end else begin
                        idx_next   = '0;
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg;
                req.wr_data = (idx_reg < FIRST_P);
                if (idx_reg == LAST_ADDR) begin
                    idx_next   = FIRST_P;
                    state_next = S_RD;
                end else begin
                    idx_next = add_s[gpc_pkg::ADDR_W-1:0];
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (!rsp.rd_a_data) begin
                    j_next     = gpc_pkg::J_W'(idx_reg) << 1;
                    state_next = S_MARK;
                end else begin
                    state_next = S_ADV;
                end
            end
            S_MARK: begin
                req.wr_en   = 1'b1;
                req.wr_addr = j_reg[gpc_pkg::ADDR_W-1:0];
                req.wr_data = 1'b1;
                j_next      = add_s;
                if (32'(add_s) > gpc_pkg::MAX_N) begin
                    state_next = S_ADV;
                end
            end
            S_ADV: begin
                if (idx_reg == HALF_ADDR) begin
                    ready_next = 1'b1;
                    state_next = S_QSET;
                end else begin
                    idx_next   = add_s[gpc_pkg::ADDR_W-1:0];
                    state_next = S_RD;
                end
            end
            S_QSET: begin
                if (n_ok_reg) begin
                    idx_next   = FIRST_P;
                    q_next     = dec_s;
                    state_next = S_QRY;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_QRY: begin
                if (idx_reg == (n_reg >> 1)) begin
                    state_next = S_DRAIN;
                end else begin
                    idx_next = add_s[gpc_pkg::ADDR_W-1:0];
                    q_next   = dec_s;
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (ctrl.take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            pend_reg  <= (state_reg == S_QRY);
        end
    end

    always_ff @(posedge aclk) begin
        n_ok_reg <= n_ok_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        q_reg    <= q_next;
        j_reg    <= j_next;
        cnt_reg  <= cnt_next;
    end

    assign stat.idle  = (state_reg == S_IDLE);
    assign stat.done  = (state_reg == S_DONE);
    assign stat.count = cnt_reg;

endmodule

// ===== sv/goldbach_partition_counter.sv =====
// Goldbach partition counter.
// Input stream (s_*): one number n per transaction in s_tdata[16:0].
// Output stream (m_*): one transaction per input, m_tdata[14:0] holds the
// number of prime pairs p <= q with p + q = n (0 for n below 4 or above
// the bitmap range, saturating at 32767).
// Primality comes from a one-bit composite bitmap in a single memory with one
// write and two registered read ports.
// Reset clears control state only. The first query after reset first sweeps
// the bitmap clear over all MAX_N + 1 entries, then runs the sieve: each
// candidate up to MAX_N/2 is read and checked, and a prime one has its
// multiples marked up to MAX_N.
// After that a query reads one bitmap pair (p, n - p) per cycle for p from 2
// up to floor(n/2); an out-of-range n skips the reads.
// One query is in flight at a time: s_tready is high only while idle, so a
// new query is taken only once the last result has left the sequencer.
// The result sits in an output register; while m_tready is low it holds, the
// next query still runs, and its result waits with s_tready low until the
// register frees.
`include "assert_macros.svh"

module goldbach_partition_counter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gpc_pkg::S_TDATA_W-1:0]   s_tdata,   // [16:0] query_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gpc_pkg::M_TDATA_W-1:0]   m_tdata    // [14:0] pair_count
);

    gpc_pkg::seq_ctrl_t ctrl;
    gpc_pkg::seq_stat_t stat;
    gpc_pkg::mem_req_t  req;
    gpc_pkg::mem_rsp_t  rsp;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [gpc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          take;

    assign s_tready   = stat.idle;
    assign take       = stat.done && (!m_tvalid_reg || m_tready);
    assign ctrl.start = s_tvalid && s_tready;
    assign ctrl.take  = take;
    assign ctrl.query = s_tdata[gpc_pkg::QRY_W-1:0];

    gpc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .req     (req),
        .rsp     (rsp)
    );

    gpc_bitmap u_bitmap (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = gpc_pkg::M_TDATA_W'(stat.count);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `GPC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "busy")
    `GPC_ASSERT(a_done_not_idle, aclk, aresetn, !(stat.done && stat.idle), "done while idle")
    `GPC_ASSERT_NEXT(a_take_fills_out, aclk, aresetn, take, m_tvalid, "result lost")

endmodule
